/* design/rbsi_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_pkg
// Shared types and constants of the ray / box slab intersection unit.
// ----------------------------------------------------------------------------
package rbsi_pkg;

	localparam int FRAC_BITS = 16;
	localparam int QBITS     = 31;

	// 2^(2*FRAC_BITS): numerator of the reciprocal
	localparam logic [63:0] ONE2    = 64'd1 << (2 * FRAC_BITS);
	// any |d| at or below this gives a reciprocal that saturates
	localparam logic [31:0] SAT_LIM = 32'(ONE2 >> QBITS);

	localparam logic signed [31:0] T_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] T_MIN = 32'sh8000_0000;

	localparam int LANE_LAT  = 1 + QBITS + 3;
	localparam int MERGE_LAT = 2;
	localparam int LAT       = LANE_LAT + MERGE_LAT;

	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_z;
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic signed [31:0] dir_z;
		logic signed [31:0] box_min_x;
		logic signed [31:0] box_min_y;
		logic signed [31:0] box_min_z;
		logic signed [31:0] box_max_x;
		logic signed [31:0] box_max_y;
		logic signed [31:0] box_max_z;
	} req_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] t_near;
		logic signed [31:0] t_far;
	} res_t;

	typedef struct packed {
		logic signed [31:0] lo;
		logic signed [31:0] hi;
	} span_t;

	typedef struct packed {
		logic        neg;
		logic [32:0] mag;
	} smag_t;

endpackage

/* design/rbsi_recip.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_recip
// Pipelined restoring divider: q = 2^(2*FRAC_BITS) / m, one quotient bit per
// stage. Valid only where m is above the saturation limit.
// ----------------------------------------------------------------------------
module rbsi_recip (
	input  logic        clk,
	input  logic [31:0] m,
	output logic [rbsi_pkg::QBITS-1:0] q
);
	import rbsi_pkg::*;

	logic [31:0]      rem_s [0:QBITS-1];
	logic [QBITS-1:0] q_s   [0:QBITS-1];
	logic [31:0]      m_s   [0:QBITS-2];

	for (genvar k = 0; k < QBITS; k++) begin : g_stage
		localparam int J = QBITS - 1 - k;
		logic [31:0]      rin;
		logic [QBITS-1:0] qin;
		logic [31:0]      min;
		logic [32:0]      trial;
		logic             ge;

		if (k == 0) begin : g_first
			assign rin = SAT_LIM;
			assign qin = '0;
			assign min = m;
		end else begin : g_next
			assign rin = rem_s[k-1];
			assign qin = q_s[k-1];
			assign min = m_s[k-1];
		end

		assign trial = {rin, ONE2[J]};
		assign ge    = trial >= {1'b0, min};

		always_ff @(posedge clk) begin
			rem_s[k] <= ge ? 32'(trial - {1'b0, min}) : trial[31:0];
			q_s[k]   <= {qin[QBITS-2:0], ge};
		end

		if (k < QBITS - 1) begin : g_carry
			always_ff @(posedge clk) begin
				m_s[k] <= min;
			end
		end
	end

	assign q = q_s[QBITS-1];

endmodule

/* design/rbsi_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_lane
// One axis: reciprocal of the direction, both plane distances, ordering.
// ----------------------------------------------------------------------------
module rbsi_lane (
	input  logic               clk,
	input  logic signed [31:0] o,
	input  logic signed [31:0] d,
	input  logic signed [31:0] pmin,
	input  logic signed [31:0] pmax,
	output rbsi_pkg::span_t    span
);
	import rbsi_pkg::*;

	typedef struct packed {
		logic  dneg;
		logic  dzero;
		logic  dsat;
		smag_t t0;
		smag_t t1;
	} car_t;

	function automatic smag_t diff_mag(logic signed [31:0] p, logic signed [31:0] org);
		logic signed [32:0] df;
		smag_t r;
		df = {p[31], p} - {org[31], org};
		r.neg = df[32];
		r.mag = df[32] ? 33'(-df) : df;
		return r;
	endfunction

	function automatic logic signed [31:0] finish(logic neg, logic [63:0] pm);
		logic [63:0] qv;
		logic signed [31:0] r;
		qv = pm >> FRAC_BITS;
		if (neg && (pm[FRAC_BITS-1:0] != '0))
			qv = qv + 64'd1;
		if (pm == '0)
			r = '0;
		else if (neg)
			r = (qv >= 64'h8000_0000) ? T_MIN : 32'(-qv);
		else
			r = (qv > 64'h7FFF_FFFF) ? T_MAX : qv[31:0];
		return r;
	endfunction

	car_t        car_s1;
	logic [31:0] m_s1;
	logic [31:0] am;
	car_t        car_d [0:QBITS-1];
	logic [QBITS-1:0] q;

	assign am = d[31] ? 32'(-d) : d;

	always_ff @(posedge clk) begin
		car_s1.dneg  <= d[31];
		car_s1.dzero <= (d == '0);
		car_s1.dsat  <= (am <= SAT_LIM);
		car_s1.t0    <= diff_mag(pmin, o);
		car_s1.t1    <= diff_mag(pmax, o);
		m_s1         <= am;
	end

	rbsi_recip u_recip (
		.clk (clk),
		.m   (m_s1),
		.q   (q)
	);

	// carry the side data alongside the divider
	always_ff @(posedge clk) begin
		car_d[0] <= car_s1;
		for (int i = 1; i < QBITS; i++)
			car_d[i] <= car_d[i-1];
	end

	car_t        c;
	logic [31:0] rm;
	logic        rneg;

	assign c    = car_d[QBITS-1];
	assign rneg = c.dneg & !c.dzero;
	always_comb begin
		if (c.dzero)
			rm = 32'h7FFF_FFFF;
		else if (c.dsat)
			rm = c.dneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
		else
			rm = {1'b0, q};
	end

	logic [63:0] p0_m, p1_m;
	logic        h0_m, h1_m, n0_m, n1_m;
	logic [31:0] rm_m;

	always_ff @(posedge clk) begin
		p0_m <= c.t0.mag[31:0] * rm;
		p1_m <= c.t1.mag[31:0] * rm;
		h0_m <= c.t0.mag[32];
		h1_m <= c.t1.mag[32];
		n0_m <= c.t0.neg ^ rneg;
		n1_m <= c.t1.neg ^ rneg;
		rm_m <= rm;
	end

	logic [63:0] s0_a, s1_a;
	logic        n0_a, n1_a;

	// the 33rd diff bit is set only for a magnitude of exactly 2^32
	always_ff @(posedge clk) begin
		s0_a <= p0_m + (h0_m ? {rm_m, 32'd0} : 64'd0);
		s1_a <= p1_m + (h1_m ? {rm_m, 32'd0} : 64'd0);
		n0_a <= n0_m;
		n1_a <= n1_m;
	end

	logic signed [31:0] t0, t1;

	assign t0 = finish(n0_a, s0_a);
	assign t1 = finish(n1_a, s1_a);

	always_ff @(posedge clk) begin
		if (t0 > t1) begin
			span.lo <= t1;
			span.hi <= t0;
		end else begin
			span.lo <= t0;
			span.hi <= t1;
		end
	end

endmodule

/* design/rbsi_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_merge
// Narrow the x interval by y, then by z; zero both distances on a miss.
// ----------------------------------------------------------------------------
module rbsi_merge (
	input  logic            clk,
	input  rbsi_pkg::span_t x,
	input  rbsi_pkg::span_t y,
	input  rbsi_pkg::span_t z,
	output rbsi_pkg::res_t  res
);
	import rbsi_pkg::*;

	span_t run_s1, z_s1;
	logic  miss_s1;
	logic  miss2;

	always_ff @(posedge clk) begin
		miss_s1   <= (y.lo > x.hi) || (x.lo > y.hi);
		run_s1.lo <= (y.lo > x.lo) ? y.lo : x.lo;
		run_s1.hi <= (y.hi < x.hi) ? y.hi : x.hi;
		z_s1      <= z;
	end

	assign miss2 = miss_s1 || (z_s1.lo > run_s1.hi) || (run_s1.lo > z_s1.hi);

	always_ff @(posedge clk) begin
		res.hit <= !miss2;
		if (miss2) begin
			res.t_near <= '0;
			res.t_far  <= '0;
		end else begin
			res.t_near <= (z_s1.lo > run_s1.lo) ? z_s1.lo : run_s1.lo;
			res.t_far  <= (z_s1.hi < run_s1.hi) ? z_s1.hi : run_s1.hi;
		end
	end

endmodule

/* design/ray_box_slab_intersect_unit.sv */
`timescale 1ns / 1ps
// Throughput: one ray / box word per cycle; busy is never raised.
// The depth is set by the 31-stage reciprocal divider in each axis lane.
// Reset clears only the valid pipeline; done stays low until words emerge.
// The receiver cannot stall: each result is shown for one cycle with done.
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_unit
// Fully pipelined slab test: three axis lanes and a merge unit.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  rbsi_pkg::req_t req,
	output logic           done,
	output rbsi_pkg::res_t res
);
	import rbsi_pkg::*;

	span_t         sx, sy, sz;
	logic [LAT-1:0] vld_q;

	assign busy = 1'b0;

	rbsi_lane u_lane_x (
		.clk(clk), .o(req.origin_x), .d(req.dir_x),
		.pmin(req.box_min_x), .pmax(req.box_max_x), .span(sx)
	);
	rbsi_lane u_lane_y (
		.clk(clk), .o(req.origin_y), .d(req.dir_y),
		.pmin(req.box_min_y), .pmax(req.box_max_y), .span(sy)
	);
	rbsi_lane u_lane_z (
		.clk(clk), .o(req.origin_z), .d(req.dir_z),
		.pmin(req.box_min_z), .pmax(req.box_max_z), .span(sz)
	);

	rbsi_merge u_merge (
		.clk(clk), .x(sx), .y(sy), .z(sz), .res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start & !busy};
		end
	end

	assign done = vld_q[LAT-1];

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##(LAT) done)
		else $error("accepted word did not complete after fixed latency");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !res.hit |-> res.t_near == '0 && res.t_far == '0)
		else $error("miss with nonzero distances");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.hit |-> res.t_near <= res.t_far)
		else $error("hit with entry beyond exit");

endmodule
